FILE: design/kcpd_pkg.sv
// Shared types, codes and constants of the key click and press detector.
`default_nettype none

package kcpd_pkg;

   // Field widths
   localparam int TIME_W      = 32;
   localparam int TOUCH_W     = 16;
   localparam int KEYS        = 5;
   localparam int CODE_W      = 3;
   localparam int STATE_W     = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 8;

   // Key codes
   localparam logic [CODE_W-1:0] CODE_NONE  = 3'd0;
   localparam logic [CODE_W-1:0] CODE_OK    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_UP    = 3'd2;
   localparam logic [CODE_W-1:0] CODE_DOWN  = 3'd3;
   localparam logic [CODE_W-1:0] CODE_LEFT  = 3'd4;
   localparam logic [CODE_W-1:0] CODE_RIGHT = 3'd5;

   // Event kinds
   localparam logic [STATE_W-1:0] EVT_NONE    = 2'd0;
   localparam logic [STATE_W-1:0] EVT_CLICKED = 2'd1;
   localparam logic [STATE_W-1:0] EVT_PRESSED = 2'd2;

   // Request kinds
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOUCH_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOUCH_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_DELAY_MS  = 2'd3;

   // Register reset values
   localparam logic                  RST_TOUCH_MODE      = 1'b0;
   localparam logic [TOUCH_W-1:0]    RST_TOUCH_THRESHOLD = 16'd40;
   localparam logic [CSR_DATA_W-1:0] RST_DEBOUNCE_MS     = 16'd50;
   localparam logic [CSR_DATA_W-1:0] RST_PRESS_DELAY_MS  = 16'd500;

   typedef logic [KEYS-1:0][TOUCH_W-1:0] touch_vec_type;

   // Settings the key picker needs
   typedef struct packed {
      logic               touch_mode;
      logic [TOUCH_W-1:0] touch_threshold;
   } pick_cfg_type;

endpackage

`default_nettype wire

FILE: design/key_click_press_detector.sv
// Top level of the key click and long-press detector.
`default_nettype none

// Takes one request per clock unless stalled: a sample (five button levels or
// touch readings with a millisecond time) or a take of the pending event, and
// returns exactly one response per request. A request is registered in the input
// stage on acceptance, then in the output register once that is free; responses
// leave at one per cycle while rsp_tready is high, a rate set by the update of
// the held key, event flag and change time, which each request reads from the
// one before it. A response waiting on rsp_tready does not block acceptance of
// one more request. Registers are written through the csr_ port; the user must
// write them only while no request is in flight, which the block does not enforce.
module key_click_press_detector
   import kcpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   // Request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // tdata fields, low bit up: now_ms[31:0], button_down[36:32], touch_ok[52:37],
   // touch_up[68:53], touch_down[84:69], touch_left[100:85], touch_right[116:101],
   // zero fill[119:117]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser fields: op[0]
   input  wire logic                   req_tuser,

   // Response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tdata fields, low bit up: key_code[2:0], key_state[4:3], event_pending[5],
   // zero fill[7:6]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,

   // Register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers
   logic                  touch_mode_ff;
   logic [TOUCH_W-1:0]    touch_threshold_ff;
   logic [CSR_DATA_W-1:0] debounce_ms_ff;
   logic [CSR_DATA_W-1:0] press_delay_ms_ff;

   // Input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_op_ff;
   logic [TIME_W-1:0]     s1_now_ff;
   logic [KEYS-1:0]       s1_button_ff;
   touch_vec_type         s1_touch_ff;

   // Held event state
   logic [CODE_W-1:0]     held_code_ff, held_code_in;
   logic [STATE_W-1:0]    held_state_ff, held_state_in;
   logic                  pending_ff, pending_in;
   logic [TIME_W-1:0]     last_change_ff, last_change_in;

   // Output stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  fire;
   logic                  req_xfer;
   logic [CODE_W-1:0]     pick_code;
   logic [TIME_W-1:0]     elapsed;
   logic                  in_window;
   logic                  held_long;
   pick_cfg_type          pick_cfg;

   // Handshakes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         touch_mode_ff      <= RST_TOUCH_MODE;
         touch_threshold_ff <= RST_TOUCH_THRESHOLD;
         debounce_ms_ff     <= RST_DEBOUNCE_MS;
         press_delay_ms_ff  <= RST_PRESS_DELAY_MS;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TOUCH_MODE:      touch_mode_ff      <= csr_data[0];
            CSR_TOUCH_THRESHOLD: touch_threshold_ff <= csr_data;
            CSR_DEBOUNCE_MS:     debounce_ms_ff     <= csr_data;
            CSR_PRESS_DELAY_MS:  press_delay_ms_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register
   assign s1_valid_in = req_xfer || (s1_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff     <= req_tuser;
         s1_now_ff    <= req_tdata[31:0];
         s1_button_ff <= req_tdata[36:32];
         s1_touch_ff  <= req_tdata[116:37];
      end
   end

   // Key selection
   assign pick_cfg.touch_mode      = touch_mode_ff;
   assign pick_cfg.touch_threshold = touch_threshold_ff;

   kcpd_key_pick u_key_pick (
      .cfg         (pick_cfg),
      .button_down (s1_button_ff),
      .touch       (s1_touch_ff),
      .code        (pick_code)
   );

   // Time since last change, modulo 2^32
   assign elapsed   = s1_now_ff - last_change_ff;
   assign in_window = elapsed < {{(TIME_W-CSR_DATA_W){1'b0}}, debounce_ms_ff};
   assign held_long = elapsed > {{(TIME_W-CSR_DATA_W){1'b0}}, press_delay_ms_ff};

   // Event state update
   always_comb begin
      held_code_in   = held_code_ff;
      held_state_in  = held_state_ff;
      pending_in     = pending_ff;
      last_change_in = last_change_ff;
      if (fire) begin
         if (s1_op_ff == OP_TAKE) begin
            held_code_in   = CODE_NONE;
            pending_in     = 1'b0;
            last_change_in = s1_now_ff;
         end else if (!in_window) begin
            if (held_code_ff == CODE_NONE) begin
               // first press
               if (pick_code != CODE_NONE) begin
                  held_code_in   = pick_code;
                  last_change_in = s1_now_ff;
               end
            end else if (pick_code == CODE_NONE) begin
               // release: click unless a long press already fired
               if (held_state_ff == EVT_PRESSED) begin
                  held_state_in = EVT_NONE;
                  held_code_in  = CODE_NONE;
               end else begin
                  held_state_in = EVT_CLICKED;
                  pending_in    = 1'b1;
               end
               last_change_in = s1_now_ff;
            end else if (held_code_ff == pick_code) begin
               // still held: repeating long press
               if (held_long) begin
                  held_state_in  = EVT_PRESSED;
                  last_change_in = s1_now_ff;
                  pending_in     = 1'b1;
               end
            end else begin
               // other key: start over with it
               pending_in     = 1'b0;
               held_state_in  = EVT_NONE;
               held_code_in   = pick_code;
               last_change_in = s1_now_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_code_ff   <= CODE_NONE;
         held_state_ff  <= EVT_NONE;
         pending_ff     <= 1'b0;
         last_change_ff <= '0;
      end else begin
         held_code_ff   <= held_code_in;
         held_state_ff  <= held_state_in;
         pending_ff     <= pending_in;
         last_change_ff <= last_change_in;
      end
   end

   // Response: take reports the state before, sample the state after
   always_comb begin
      if (s1_op_ff == OP_TAKE) begin
         rsp_data_in = {2'b00, pending_ff, held_state_ff, held_code_ff};
      end else begin
         rsp_data_in = {2'b00, pending_in, held_state_in, held_code_in};
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // A take leaves no pending event and no held key
   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      fire && s1_op_ff == OP_TAKE |=> !pending_ff && held_code_ff == CODE_NONE)
      else $error("take did not clear the held event");

   // Every processed request shows up as a response
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request produced no response");

   // A stalled request stays in the input stage
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |=> s1_valid_ff && $stable(s1_now_ff))
      else $error("stalled request lost from input stage");
`endif

endmodule

`default_nettype wire

FILE: design/kcpd_key_pick.sv
// Active-key detection and fixed-priority key selection.
`default_nettype none

module kcpd_key_pick
   import kcpd_pkg::*;
(
   input  wire pick_cfg_type        cfg,
   input  wire logic [KEYS-1:0]     button_down,
   input  wire touch_vec_type       touch,
   output logic [CODE_W-1:0]        code
);

   logic [KEYS-1:0] active;

   // Per-key activity: touch compare or button level
   always_comb begin
      for (int k = 0; k < KEYS; k++) begin
         if (cfg.touch_mode) begin
            active[k] = touch[k] < cfg.touch_threshold;
         end else begin
            active[k] = button_down[k];
         end
      end
   end

   // Lowest key index wins: OK, up, down, left, right
   always_comb begin
      code = CODE_NONE;
      for (int k = KEYS - 1; k >= 0; k--) begin
         if (active[k]) begin
            code = CODE_W'(k + 1);
         end
      end
   end

endmodule

`default_nettype wire
